// ===== design/tmiu_pkg.sv =====
// Package for the triclinic minimum-image unwrap block.
// Payload types, operation codes and sizes; no dependencies.
`default_nettype none
package tmiu_pkg;
   localparam int ENTITY_COUNT_DEF = 4096;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int CFG_WIDTH        = 63;
   localparam int CFG_IDX_WIDTH    = 3;
   localparam int CELL_WIDTH       = 12;
   localparam int RECIP_FRAC       = 36;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_UNWRAP = 1'b1
   } op_type;

   typedef enum logic [CFG_IDX_WIDTH-1:0] {
      REG_CELL_A  = 3'd0,
      REG_CELL_B  = 3'd1,
      REG_CELL_C  = 3'd2,
      REG_RECIP_A = 3'd3,
      REG_RECIP_B = 3'd4,
      REG_RECIP_C = 3'd5
   } reg_type;

   typedef struct packed {
      logic               operation;
      logic [11:0]        entity;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
      logic signed [11:0] cells_a;
      logic signed [11:0] cells_b;
      logic signed [11:0] cells_c;
      logic               moved;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/tmiu_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tmiu_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/triclinic_minimum_image_unwrap.sv =====
// Top level of the triclinic minimum-image unwrap block.
// Uses tmiu_pkg and tmiu_ram (reference store).
//
//  channel | ports                         | handshake
//  --------+-------------------------------+-------------------------------
//  request | start, busy, req_payload      | taken when start & !busy
//  result  | rsp_valid, rsp_payload        | one-cycle strobe, no stall
//  config  | csr_we, csr_index, csr_wdata  | written when csr_we
//
// An unwrap holds busy through read, difference, three reciprocal dot products,
// floor, 27 candidates one per cycle through a two-stage shared multiply/compare
// unit, a drain state and a store state. Its result strobes in the cycle after
// the store state, when the next transaction can be taken; the candidate sweep
// sets the rate. Loads and out-of-range items pass only through the read and
// skip states. Reset clears control and the configuration registers only; the
// reference store is undefined until loaded. Results cannot be stalled.
`default_nettype none
module triclinic_minimum_image_unwrap
   import tmiu_pkg::*;
#(
   parameter int ENTITY_COUNT = ENTITY_COUNT_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire req_type                  req_payload,
   output      logic                     rsp_valid,
   output      rsp_type                  rsp_payload,
   input  wire logic                     csr_we,
   input  wire logic [CFG_IDX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]     csr_wdata
);
   localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int AW = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
   localparam int DEPTH = 1 << AW;
   localparam int IW = (AW < 12) ? AW : 12;
   // residual component beyond which a candidate can never beat |d|^2
   localparam logic signed [48:0] R_LIM = 49'sd17179869183;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_READ  = 9'b0_0000_0010,
      S_DIFF  = 9'b0_0000_0100,
      S_DOT   = 9'b0_0000_1000,
      S_FLOOR = 9'b0_0001_0000,
      S_CAND  = 9'b0_0010_0000,
      S_STORE = 9'b0_0100_0000,
      S_SKIP  = 9'b0_1000_0000,
      S_DRAIN = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [CFG_WIDTH-1:0] cfg_ff [6];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) cfg_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CELL_A:  cfg_ff[0] <= csr_wdata;
            REG_CELL_B:  cfg_ff[1] <= csr_wdata;
            REG_CELL_C:  cfg_ff[2] <= csr_wdata;
            REG_RECIP_A: cfg_ff[3] <= csr_wdata;
            REG_RECIP_B: cfg_ff[4] <= csr_wdata;
            REG_RECIP_C: cfg_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic signed [20:0] fld(input logic [CFG_WIDTH-1:0] r,
                                              input logic [1:0] k);
      logic signed [20:0] f;
      case (k)
         2'd0:    f = r[20:0];
         2'd1:    f = r[41:21];
         default: f = r[62:42];
      endcase
      return f;
   endfunction

   function automatic logic signed [31:0] satc(input logic signed [39:0] x);
      logic signed [39:0] hi, lo;
      hi = (40'sd1 <<< (CW - 1)) - 40'sd1;
      lo = -hi - 40'sd1;
      if (x > hi) return hi[31:0];
      if (x < lo) return lo[31:0];
      return x[31:0];
   endfunction

   // transaction registers
   req_type             req_ff;
   logic signed [31:0]  t_ff [3];
   logic signed [32:0]  d_ff [3];
   logic signed [55:0]  acc_ff;
   logic signed [20:0]  c_ff [3];
   logic [1:0]          row_ff, col_ff;
   logic [1:0]          ox_ff, oy_ff, oz_ff;
   logic signed [22:0]  bn_ff [3];
   logic signed [38:0]  bv_ff [3];
   logic [69:0]         best_ff;
   logic [AW-1:0]       addr_ff;

   // candidate pipeline registers
   logic signed [22:0]  nq_ff [3];
   logic signed [38:0]  vq_ff [3];
   logic signed [34:0]  rq_ff [3];
   logic                farq_ff;
   logic                pv_ff;

   // reference store
   logic            ram_we;
   logic [95:0]     ram_wdata, ram_rdata;
   logic [AW-1:0]   ram_raddr;
   logic signed [31:0] newref [3];

   assign ram_raddr = AW'(req_payload.entity);

   tmiu_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_ref (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic in_range;
   always_comb begin
      in_range = (req_payload.entity < 12'(ENTITY_COUNT)) ||
                 (ENTITY_COUNT >= 4096);
      if (IW < 12 && ENTITY_COUNT < 4096) begin
         in_range = ({20'd0, req_payload.entity} < 32'(ENTITY_COUNT));
      end
   end
   logic range_ff;

   // dot-product term: one 21 x 33 multiply per cycle
   logic signed [53:0] dot_term;
   assign dot_term = fld(cfg_ff[3'(row_ff) + 3'd3], col_ff) * d_ff[col_ff];

   // candidate stage 1: counts, lattice translation and residual
   logic signed [22:0] n [3];
   logic signed [43:0] pr [3][3];
   logic signed [47:0] v [3];
   logic signed [48:0] r [3];
   logic               far;
   always_comb begin
      n[0] = 23'(c_ff[0]) + 23'($signed({1'b0, ox_ff})) - 23'sd1;
      n[1] = 23'(c_ff[1]) + 23'($signed({1'b0, oy_ff})) - 23'sd1;
      n[2] = 23'(c_ff[2]) + 23'($signed({1'b0, oz_ff})) - 23'sd1;
      far = 1'b0;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            pr[i][j] = n[i] * fld(cfg_ff[i], 2'(j));
         end
         v[j] = (48'(pr[0][j]) + 48'(pr[1][j]) + 48'(pr[2][j])) <<< 6;
         r[j] = 49'(v[j]) - 49'(d_ff[j]);
         far = far || (r[j] > R_LIM) || (r[j] < -R_LIM);
      end
   end

   // candidate stage 2: squared distance and compare
   logic signed [69:0] sq [3];
   logic [71:0]        cand_dist;
   logic               cand_take;
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq[j] = rq_ff[j] * rq_ff[j];
      end
      cand_dist = 72'($unsigned(sq[0])) + 72'($unsigned(sq[1])) + 72'($unsigned(sq[2]));
      cand_take = pv_ff && !farq_ff && (cand_dist < 72'(best_ff));
   end

   // initial best: |d|^2
   logic signed [65:0] dq [3];
   logic [69:0]        dsq;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dq[k] = d_ff[k] * d_ff[k];
      end
      dsq = 70'($unsigned(dq[0])) + 70'($unsigned(dq[1])) + 70'($unsigned(dq[2]));
   end

   logic cand_last;
   assign cand_last = (ox_ff == 2'd2) && (oy_ff == 2'd2) && (oz_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_READ;
         S_READ:  state_in = (req_ff.operation == OP_UNWRAP && range_ff) ? S_DIFF
                                                                         : S_SKIP;
         S_DIFF:  state_in = S_DOT;
         S_DOT:   if (row_ff == 2'd2 && col_ff == 2'd2) state_in = S_FLOOR;
         S_FLOOR: state_in = S_CAND;
         S_CAND:  if (cand_last) state_in = S_DRAIN;
         S_DRAIN: state_in = S_STORE;
         S_STORE: state_in = S_IDLE;
         S_SKIP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            req_ff   <= req_payload;
            range_ff <= in_range;
            addr_ff  <= AW'(req_payload.entity);
            t_ff[0]  <= satc(40'(req_payload.target_x));
            t_ff[1]  <= satc(40'(req_payload.target_y));
            t_ff[2]  <= satc(40'(req_payload.target_z));
            row_ff   <= 2'd0;
            col_ff   <= 2'd0;
            acc_ff   <= '0;
         end
         S_READ: begin
            d_ff[0] <= 33'(t_ff[0]) - 33'($signed(ram_rdata[31:0]));
            d_ff[1] <= 33'(t_ff[1]) - 33'($signed(ram_rdata[63:32]));
            d_ff[2] <= 33'(t_ff[2]) - 33'($signed(ram_rdata[95:64]));
         end
         S_DIFF: ;
         S_DOT: begin
            if (col_ff == 2'd2) begin
               c_ff[row_ff] <= 21'((acc_ff + 56'(dot_term)) >>> RECIP_FRAC);
               acc_ff <= '0;
               col_ff <= 2'd0;
               row_ff <= row_ff + 2'd1;
            end else begin
               acc_ff <= acc_ff + 56'(dot_term);
               col_ff <= col_ff + 2'd1;
            end
         end
         S_FLOOR: begin
            best_ff <= dsq;
            pv_ff   <= 1'b0;
            ox_ff <= 2'd0; oy_ff <= 2'd0; oz_ff <= 2'd0;
            for (int k = 0; k < 3; k++) begin
               bn_ff[k] <= '0;
               bv_ff[k] <= '0;
            end
         end
         S_CAND: begin
            if (cand_take) begin
               best_ff <= cand_dist[69:0];
               for (int k = 0; k < 3; k++) begin
                  bn_ff[k] <= nq_ff[k];
                  bv_ff[k] <= vq_ff[k];
               end
            end
            for (int k = 0; k < 3; k++) begin
               nq_ff[k] <= n[k];
               vq_ff[k] <= 39'(v[k]);
               rq_ff[k] <= 35'(r[k]);
            end
            farq_ff <= far;
            pv_ff   <= 1'b1;
            if (oz_ff == 2'd2) begin
               oz_ff <= 2'd0;
               if (oy_ff == 2'd2) begin
                  oy_ff <= 2'd0;
                  ox_ff <= ox_ff + 2'd1;
               end else begin
                  oy_ff <= oy_ff + 2'd1;
               end
            end else begin
               oz_ff <= oz_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            // last candidate leaves stage 2
            if (cand_take) begin
               best_ff <= cand_dist[69:0];
               for (int k = 0; k < 3; k++) begin
                  bn_ff[k] <= nq_ff[k];
                  bv_ff[k] <= vq_ff[k];
               end
            end
            pv_ff <= 1'b0;
         end
         default: ;
      endcase
   end

   // result and write-back
   logic signed [31:0] sh [3];
   logic signed [11:0] cn [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = satc(-40'(bv_ff[k]));
         newref[k] = satc(40'(t_ff[k]) + 40'(sh[k]));
         if (-24'(bn_ff[k]) > 24'sd2047)       cn[k] = 12'sd2047;
         else if (-24'(bn_ff[k]) < -24'sd2048) cn[k] = -12'sd2048;
         else                                 cn[k] = 12'(-24'(bn_ff[k]));
      end
      ram_we = 1'b0;
      ram_wdata = {newref[2], newref[1], newref[0]};
      if (state_ff == S_STORE) ram_we = 1'b1;
      if (state_ff == S_SKIP && range_ff && req_ff.operation == OP_LOAD) begin
         ram_we = 1'b1;
         ram_wdata = {t_ff[2], t_ff[1], t_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_STORE) || (state_ff == S_SKIP);
      end
      if (state_ff == S_STORE) begin
         rsp_payload.shift_x <= sh[0];
         rsp_payload.shift_y <= sh[1];
         rsp_payload.shift_z <= sh[2];
         rsp_payload.cells_a <= cn[0];
         rsp_payload.cells_b <= cn[1];
         rsp_payload.cells_c <= cn[2];
         rsp_payload.moved   <= (bv_ff[0] != 0) || (bv_ff[1] != 0) || (bv_ff[2] != 0);
      end else begin
         rsp_payload <= '0;
      end
   end
endmodule
`default_nettype wire
